// ===== hdl/rti_pkg.sv =====
`default_nettype none
package rti_pkg;

  // Field and datapath widths
  localparam int CoordW = 32;
  localparam int EpsW   = 63;
  localparam int WideW  = 104;
  localparam int TQuoW  = 48;
  localparam int UQuoW  = 17;
  localparam int TFracW = 32;

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ORIGIN_X = 3'd0;
  localparam cfg_idx_t CFG_ORIGIN_Y = 3'd1;
  localparam cfg_idx_t CFG_ORIGIN_Z = 3'd2;
  localparam cfg_idx_t CFG_DIR_X    = 3'd3;
  localparam cfg_idx_t CFG_DIR_Y    = 3'd4;
  localparam cfg_idx_t CFG_DIR_Z    = 3'd5;
  localparam cfg_idx_t CFG_DET_EPS  = 3'd6;

  localparam logic [CoordW-1:0] DIR_Z_RESET = 32'd16777216;
  localparam logic [EpsW-1:0]   EPS_RESET   = 63'd109951163;

  typedef logic [2:0][CoordW-1:0] coord3_t;
  typedef logic signed [32:0]     edge_t;
  typedef logic signed [WideW-1:0] swide_t;
  typedef logic [WideW-1:0]       ufix_t;

  typedef struct packed {
    coord3_t org;
    coord3_t dir;
  } ray_t;

  // Raw dot products leaving the geometry pipeline
  typedef struct packed {
    swide_t det;
    swide_t u;
    swide_t v;
    swide_t t;
  } dots_t;

  // Classified request entering the divider
  typedef struct packed {
    logic  hit;
    logic  t_neg;
    logic  t_ovf;
    ufix_t det;
    ufix_t t_mag;
    ufix_t u;
    ufix_t v;
  } cls_t;

  typedef struct packed {
    logic             hit;
    logic [TQuoW-1:0] t;
    logic [UQuoW-1:0] u;
    logic [UQuoW-1:0] v;
  } res_t;

  // One restoring division step: {quotient bit, new remainder}
  function automatic logic [WideW:0] div_step(ufix_t rem, logic nbit, ufix_t den);
    ufix_t sh;
    sh = {rem[WideW-2:0], nbit};
    if (sh >= den) begin
      return {1'b1, sh - den};
    end
    return {1'b0, sh};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ray_triangle_intersect.sv =====
`default_nettype none
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_vert0_x .. in_vert2_z, signed Q23.8
// out_      output     out_valid/out_stall out_hit, out_distance_t, out_bary_u/v
// cfg_      input      cfg_we              cfg_index, cfg_data
// One triangle enters per cycle while in_stall is low; its result is offered once the request
// has passed 58 register stages: 6 geometry, 2 classify, 50 divide.
// Latency is set by the 48-step restoring divider for t, one quotient bit per stage.
// rst_n is synchronous: it clears all valid bits and loads register defaults.
// When a result waits under out_stall, the whole pipeline holds and in_stall rises.
module ray_triangle_intersect import rti_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [CoordW-1:0] in_vert0_x,
  input  logic signed [CoordW-1:0] in_vert0_y,
  input  logic signed [CoordW-1:0] in_vert0_z,
  input  logic signed [CoordW-1:0] in_vert1_x,
  input  logic signed [CoordW-1:0] in_vert1_y,
  input  logic signed [CoordW-1:0] in_vert1_z,
  input  logic signed [CoordW-1:0] in_vert2_x,
  input  logic signed [CoordW-1:0] in_vert2_y,
  input  logic signed [CoordW-1:0] in_vert2_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_hit,
  output logic signed [TQuoW-1:0]  out_distance_t,
  output logic [UQuoW-1:0]         out_bary_u,
  output logic [UQuoW-1:0]         out_bary_v,
  input  logic                     cfg_we,
  input  cfg_idx_t                 cfg_index,
  input  logic [EpsW-1:0]          cfg_data
);

  ray_t            ray_r;
  logic [EpsW-1:0] eps_r;
  logic            adv;
  logic            geo_vld, cls_vld;
  dots_t           dots;
  cls_t            cls;
  res_t            res;
  coord3_t         v0, v1, v2;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r.org <= '0;
      ray_r.dir <= {DIR_Z_RESET, {(2*CoordW){1'b0}}};
      eps_r     <= EPS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X: ray_r.org[0] <= cfg_data[CoordW-1:0];
        CFG_ORIGIN_Y: ray_r.org[1] <= cfg_data[CoordW-1:0];
        CFG_ORIGIN_Z: ray_r.org[2] <= cfg_data[CoordW-1:0];
        CFG_DIR_X:    ray_r.dir[0] <= cfg_data[CoordW-1:0];
        CFG_DIR_Y:    ray_r.dir[1] <= cfg_data[CoordW-1:0];
        CFG_DIR_Z:    ray_r.dir[2] <= cfg_data[CoordW-1:0];
        CFG_DET_EPS:  eps_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the whole pipeline while a result waits
  assign in_stall = out_valid && out_stall;
  assign adv      = !in_stall;

  assign v0 = {in_vert0_z, in_vert0_y, in_vert0_x};
  assign v1 = {in_vert1_z, in_vert1_y, in_vert1_x};
  assign v2 = {in_vert2_z, in_vert2_y, in_vert2_x};

  rti_geom u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .v0      (v0),
    .v1      (v1),
    .v2      (v2),
    .ray     (ray_r),
    .out_vld (geo_vld),
    .dots    (dots)
  );

  rti_check u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (geo_vld),
    .dots    (dots),
    .eps     (eps_r),
    .out_vld (cls_vld),
    .cls     (cls)
  );

  rti_divide u_divide (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (cls_vld),
    .cls     (cls),
    .out_vld (out_valid),
    .res     (res)
  );

  assign out_hit        = res.hit;
  assign out_distance_t = res.t;
  assign out_bary_u     = res.u;
  assign out_bary_v     = res.v;

endmodule
`default_nettype wire

// ===== hdl/rti_geom.sv =====
`default_nettype none
module rti_geom import rti_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  logic    in_vld,
  input  coord3_t v0,
  input  coord3_t v1,
  input  coord3_t v2,
  input  ray_t    ray,
  output logic    out_vld,
  output dots_t   dots
);

  typedef logic signed [64:0] m65_t;
  typedef logic signed [65:0] m66_t;
  typedef logic signed [66:0] m67_t;
  typedef logic signed [67:0] m68_t;

  localparam int NX1 [3] = '{1, 2, 0};
  localparam int NX2 [3] = '{2, 0, 1};

  logic [5:0] vld_r;

  edge_t e1_1r [3], e2_1r [3], tv_1r [3];
  edge_t e1_2r [3], e2_2r [3], tv_2r [3];
  edge_t e1_3r [3], e2_3r [3], tv_3r [3];
  m65_t  pa_r [3], pb_r [3];
  m66_t  qa_r [3], qb_r [3];
  m66_t  p_r [3];
  m67_t  q_r [3];
  m68_t  dh_r [3], dl_r [3], uh_r [3], ul_r [3];
  m68_t  vh_r [3], vl_r [3], th_r [3], tl_r [3];
  swide_t dp_r [3], up_r [3], vp_r [3], tp_r [3];
  dots_t dots_r;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        // Edges and vertex-to-origin vector
        e1_1r[k] <= edge_t'($signed(v1[k])) - edge_t'($signed(v0[k]));
        e2_1r[k] <= edge_t'($signed(v2[k])) - edge_t'($signed(v0[k]));
        tv_1r[k] <= edge_t'($signed(ray.org[k])) - edge_t'($signed(v0[k]));

        // Cross product terms
        pa_r[k] <= m65_t'($signed(ray.dir[NX1[k]])) * m65_t'(e2_1r[NX2[k]]);
        pb_r[k] <= m65_t'($signed(ray.dir[NX2[k]])) * m65_t'(e2_1r[NX1[k]]);
        qa_r[k] <= m66_t'(tv_1r[NX1[k]]) * m66_t'(e1_1r[NX2[k]]);
        qb_r[k] <= m66_t'(tv_1r[NX2[k]]) * m66_t'(e1_1r[NX1[k]]);
        e1_2r[k] <= e1_1r[k];
        e2_2r[k] <= e2_1r[k];
        tv_2r[k] <= tv_1r[k];

        // Cross products pvec and qvec
        p_r[k] <= m66_t'(pa_r[k]) - m66_t'(pb_r[k]);
        q_r[k] <= m67_t'(qa_r[k]) - m67_t'(qb_r[k]);
        e1_3r[k] <= e1_2r[k];
        e2_3r[k] <= e2_2r[k];
        tv_3r[k] <= tv_2r[k];

        // Split wide operands into high and low partial products
        dh_r[k] <= m68_t'(e1_3r[k]) * m68_t'($signed(p_r[k][65:33]));
        dl_r[k] <= m68_t'(e1_3r[k]) * m68_t'($signed({1'b0, p_r[k][32:0]}));
        uh_r[k] <= m68_t'(tv_3r[k]) * m68_t'($signed(p_r[k][65:33]));
        ul_r[k] <= m68_t'(tv_3r[k]) * m68_t'($signed({1'b0, p_r[k][32:0]}));
        vh_r[k] <= m68_t'($signed(ray.dir[k])) * m68_t'($signed(q_r[k][66:33]));
        vl_r[k] <= m68_t'($signed(ray.dir[k])) * m68_t'($signed({1'b0, q_r[k][32:0]}));
        th_r[k] <= m68_t'(e2_3r[k]) * m68_t'($signed(q_r[k][66:33]));
        tl_r[k] <= m68_t'(e2_3r[k]) * m68_t'($signed({1'b0, q_r[k][32:0]}));

        // Recombine partial products
        dp_r[k] <= (swide_t'(dh_r[k]) <<< 33) + swide_t'(dl_r[k]);
        up_r[k] <= (swide_t'(uh_r[k]) <<< 33) + swide_t'(ul_r[k]);
        vp_r[k] <= (swide_t'(vh_r[k]) <<< 33) + swide_t'(vl_r[k]);
        tp_r[k] <= (swide_t'(th_r[k]) <<< 33) + swide_t'(tl_r[k]);
      end

      // Sum the dot products
      dots_r.det <= dp_r[0] + dp_r[1] + dp_r[2];
      dots_r.u   <= up_r[0] + up_r[1] + up_r[2];
      dots_r.v   <= vp_r[0] + vp_r[1] + vp_r[2];
      dots_r.t   <= tp_r[0] + tp_r[1] + tp_r[2];
    end
  end

  assign out_vld = vld_r[5];
  assign dots    = dots_r;

endmodule
`default_nettype wire

// ===== hdl/rti_check.sv =====
`default_nettype none
module rti_check import rti_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  dots_t          dots,
  input  logic [EpsW-1:0] eps,
  output logic           out_vld,
  output cls_t           cls
);

  logic [1:0] vld_r;
  swide_t det_r, u_r, v_r, t_r;
  cls_t   cls_r;
  logic   neg;
  logic   miss;
  ufix_t  t_abs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[0], in_vld};
    end
  end

  // Flip all signs when det is negative
  assign neg = dots.det[WideW-1];

  always_comb begin
    miss = (det_r == '0) || (ufix_t'(det_r) < ufix_t'(eps)) ||
           u_r[WideW-1] || (u_r > det_r) || v_r[WideW-1] || ((u_r + v_r) > det_r);
    t_abs = t_r[WideW-1] ? ufix_t'(-t_r) : ufix_t'(t_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det_r <= neg ? -dots.det : dots.det;
      u_r   <= neg ? -dots.u   : dots.u;
      v_r   <= neg ? -dots.v   : dots.v;
      t_r   <= neg ? -dots.t   : dots.t;

      // Reject and prepare division operands
      cls_r.hit   <= !miss;
      cls_r.t_neg <= t_r[WideW-1];
      cls_r.t_ovf <= {16'b0, t_abs} >= {ufix_t'(det_r), 16'b0};
      cls_r.det   <= ufix_t'(det_r);
      cls_r.t_mag <= t_abs;
      cls_r.u     <= ufix_t'(u_r);
      cls_r.v     <= ufix_t'(v_r);
    end
  end

  assign out_vld = vld_r[1];
  assign cls     = cls_r;

endmodule
`default_nettype wire

// ===== hdl/rti_divide.sv =====
`default_nettype none
module rti_divide import rti_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic in_vld,
  input  cls_t cls,
  output logic out_vld,
  output res_t res
);

  typedef struct packed {
    logic             hit;
    logic             t_neg;
    logic             t_ovf;
    ufix_t            den;
    ufix_t            t_num;
    ufix_t            t_rem;
    logic [TQuoW-1:0] t_quo;
    logic             u_lsb;
    logic             v_lsb;
    ufix_t            u_rem;
    ufix_t            v_rem;
    logic [UQuoW-1:0] u_quo;
    logic [UQuoW-1:0] v_quo;
  } dstage_t;

  logic [TQuoW+1:0] vld_r;
  dstage_t          st_r [TQuoW+1];
  dstage_t          lst;
  res_t             res_r;
  logic             sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[TQuoW:0], in_vld};
    end
  end

  // Load the first remainders
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0].hit   <= cls.hit;
      st_r[0].t_neg <= cls.t_neg;
      st_r[0].t_ovf <= cls.t_ovf;
      st_r[0].den   <= cls.det;
      st_r[0].t_num <= cls.t_mag;
      st_r[0].t_rem <= {16'b0, cls.t_mag[WideW-1:16]};
      st_r[0].t_quo <= '0;
      st_r[0].u_lsb <= cls.u[0];
      st_r[0].v_lsb <= cls.v[0];
      st_r[0].u_rem <= {1'b0, cls.u[WideW-1:1]};
      st_r[0].v_rem <= {1'b0, cls.v[WideW-1:1]};
      st_r[0].u_quo <= '0;
      st_r[0].v_quo <= '0;
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < TQuoW; k++) begin : g_step
    localparam int QI = TQuoW - 1 - k;
    logic             t_bit;
    logic [WideW:0]   rt;
    dstage_t          st_nxt;

    if (QI >= TFracW) begin : g_tbit
      assign t_bit = st_r[k].t_num[QI-TFracW];
    end else begin : g_tzero
      assign t_bit = 1'b0;
    end
    assign rt = div_step(st_r[k].t_rem, t_bit, st_r[k].den);

    if (k < UQuoW) begin : g_uv
      localparam int UI = UQuoW - 1 - k;
      logic           u_bit, v_bit;
      logic [WideW:0] ru, rv;
      assign u_bit = (UI == UQuoW - 1) ? st_r[k].u_lsb : 1'b0;
      assign v_bit = (UI == UQuoW - 1) ? st_r[k].v_lsb : 1'b0;
      assign ru = div_step(st_r[k].u_rem, u_bit, st_r[k].den);
      assign rv = div_step(st_r[k].v_rem, v_bit, st_r[k].den);
      always_comb begin
        st_nxt           = st_r[k];
        st_nxt.t_rem     = rt[WideW-1:0];
        st_nxt.t_quo[QI] = rt[WideW];
        st_nxt.u_rem     = ru[WideW-1:0];
        st_nxt.u_quo[UI] = ru[WideW];
        st_nxt.v_rem     = rv[WideW-1:0];
        st_nxt.v_quo[UI] = rv[WideW];
      end
    end else begin : g_tonly
      always_comb begin
        st_nxt           = st_r[k];
        st_nxt.t_rem     = rt[WideW-1:0];
        st_nxt.t_quo[QI] = rt[WideW];
      end
    end

    // Advance one stage
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k+1] <= st_nxt;
      end
    end
  end

  // Saturate t and zero a miss
  assign lst = st_r[TQuoW];
  assign sat = lst.t_neg ? (lst.t_ovf || (lst.t_quo > {1'b1, {(TQuoW-1){1'b0}}}))
                         : (lst.t_ovf || lst.t_quo[TQuoW-1]);

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r.hit <= lst.hit;
      if (!lst.hit) begin
        res_r.t <= '0;
        res_r.u <= '0;
        res_r.v <= '0;
      end else begin
        if (lst.t_neg) begin
          res_r.t <= sat ? {1'b1, {(TQuoW-1){1'b0}}} : -lst.t_quo;
        end else begin
          res_r.t <= sat ? {1'b0, {(TQuoW-1){1'b1}}} : lst.t_quo;
        end
        res_r.u <= lst.u_quo;
        res_r.v <= lst.v_quo;
      end
    end
  end

  assign out_vld = vld_r[TQuoW+1];
  assign res     = res_r;

endmodule
`default_nettype wire

// ===== hdl/rti_checker.sv =====
`default_nettype none
module rti_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic                out_hit,
  input logic signed [47:0]  out_distance_t,
  input logic [16:0]         out_bary_u,
  input logic [16:0]         out_bary_v
);

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_distance_t) && $stable(out_hit) &&
                                  $stable(out_bary_u) && $stable(out_bary_v)))
    else $error("stalled result changed");

  // Input backs up only behind a blocked result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // A miss carries zero values
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |->
      (out_distance_t == '0 && out_bary_u == '0 && out_bary_v == '0))
    else $error("miss with nonzero values");

  // Barycentrics of a hit stay inside the triangle
  a_bary_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (({1'b0, out_bary_u} + {1'b0, out_bary_v}) <= 18'd65536))
    else $error("barycentric sum above one");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);
`default_nettype wire
